/* src/hgcd_pkg.sv */
// Shared types, constants and arithmetic helpers for the haversine distance pipeline.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hgcd_pkg;

  // Pipeline geometry
  localparam int CORDIC_STAGES = 32;
  localparam int SQRT_STEPS    = 31;
  localparam int IDX_W         = 6;   // CORDIC stage index, 0 to 63
  localparam int SQ_IDX_W      = 5;   // square root digit index

  // Field and datapath widths
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int DIST_W     = 31;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 32;
  localparam int HW         = 35;     // half-unit angle
  localparam int MW         = 31;     // folded angle magnitude
  localparam int CW         = 36;     // CORDIC x, y, z
  localparam int SW         = 61;     // square root remainder and root

  // Total register stages from input to output register
  localparam int PIPE_LAT = 1 + 3 + CORDIC_STAGES + 3 + SQRT_STEPS + CORDIC_STAGES + 2;

  // Angle reduction in units of 0.5e-7 degree
  localparam logic signed [HW-1:0] HALF_360 = 35'sd7200000000;
  localparam logic signed [HW-1:0] HALF_180 = 35'sd3600000000;
  localparam logic signed [HW-1:0] HALF_90  = 35'sd1800000000;
  localparam logic [31:0]          ANG_SCALE = 32'd4024455254;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic [30:0]          Q30_ONE     = 31'd1073741824;
  localparam logic [31:0]          RADIUS2_CM  = 32'd1275627400;  // twice the radius
  localparam logic [DIST_W-1:0]    DIST_MAX    = 31'd2003750834;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
  } sqrt_t;

  // Arctangent of 2^-i in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      6'd0:    v = 36'sd843314857;
      6'd1:    v = 36'sd497837829;
      6'd2:    v = 36'sd263043837;
      6'd3:    v = 36'sd133525159;
      6'd4:    v = 36'sd67021687;
      6'd5:    v = 36'sd33543516;
      6'd6:    v = 36'sd16775851;
      6'd7:    v = 36'sd8388437;
      6'd8:    v = 36'sd4194283;
      6'd9:    v = 36'sd2097149;
      6'd10:   v = 36'sd1048576;
      default: v = (i <= 6'd30) ? (36'sd1 <<< (6'd30 - i)) : '0;
    endcase
    return v;
  endfunction

  // Q2.30 product, rounded half up with a flooring shift
  function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    logic signed [2*CW-1:0] r;
    p = a * b;
    r = (p + (72'sd1 <<< 29)) >>> 30;
    return r[CW-1:0];
  endfunction

endpackage

/* src/hgcd_angle_prep.sv */
// Angle front end: wraps a half-unit angle, folds it into +-90 degrees and scales it
// to Q2.30 radians over three register stages. Depends on hgcd_pkg.
`timescale 1ns / 1ps

module hgcd_angle_prep (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [hgcd_pkg::HW-1:0] h,
  output logic signed [hgcd_pkg::CW-1:0] z,
  output logic                          neg_cos
);

  logic signed [hgcd_pkg::HW-1:0] r;
  logic                          nc;
  logic                          neg;
  logic signed [hgcd_pkg::HW-1:0] mag;
  logic [hgcd_pkg::MW-1:0]        mag_r;
  logic                          negz_r;
  logic                          ncos_a_r;
  logic [62:0]                   prod_r;
  logic                          negz_b_r;
  logic                          ncos_b_r;
  logic [63:0]                   prod_rnd;
  logic signed [hgcd_pkg::CW-1:0] zmag;
  logic signed [hgcd_pkg::CW-1:0] z_r;
  logic                          ncos_c_r;

  // Wrap into [-180, 180) and fold into [-90, 90]
  always_comb begin
    r  = h;
    nc = 1'b0;
    if (r >= hgcd_pkg::HALF_180) r = r - hgcd_pkg::HALF_360;
    if (r < -hgcd_pkg::HALF_180) r = r + hgcd_pkg::HALF_360;
    if (r > hgcd_pkg::HALF_90) begin
      r  = hgcd_pkg::HALF_180 - r;
      nc = 1'b1;
    end
    if (r < -hgcd_pkg::HALF_90) begin
      r  = -hgcd_pkg::HALF_180 - r;
      nc = 1'b1;
    end
    neg = r[hgcd_pkg::HW-1];
    mag = neg ? -r : r;
  end

  // Rounded scaling to radians
  assign prod_rnd = {1'b0, prod_r} + 64'h8000_0000;
  assign zmag     = hgcd_pkg::CW'(prod_rnd[63:32]);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r    <= mag[hgcd_pkg::MW-1:0];
      negz_r   <= neg;
      ncos_a_r <= nc;
      prod_r   <= 63'(mag_r) * 63'(hgcd_pkg::ANG_SCALE);
      negz_b_r <= negz_r;
      ncos_b_r <= ncos_a_r;
      z_r      <= negz_b_r ? -zmag : zmag;
      ncos_c_r <= ncos_b_r;
    end
  end

  assign z       = z_r;
  assign neg_cos = ncos_c_r;

endmodule

/* src/hgcd_cordic_cell.sv */
// One CORDIC micro-rotation cell, rotation or vectoring mode, with its output register.
// Depends on hgcd_pkg.
`timescale 1ns / 1ps

module hgcd_cordic_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       vec,
  input  logic [hgcd_pkg::IDX_W-1:0] stage,
  input  hgcd_pkg::cordic_t          in_c,
  output hgcd_pkg::cordic_t          out_c
);

  logic signed [hgcd_pkg::CW-1:0] sx;
  logic signed [hgcd_pkg::CW-1:0] sy;
  logic signed [hgcd_pkg::CW-1:0] at;
  logic                          pos;
  hgcd_pkg::cordic_t             c_nxt;
  hgcd_pkg::cordic_t             c_r;

  // Direction: rotation follows z, vectoring drives y toward zero
  always_comb begin
    sx  = in_c.x >>> stage;
    sy  = in_c.y >>> stage;
    at  = hgcd_pkg::atan_q30(stage);
    pos = vec ? in_c.y[hgcd_pkg::CW-1] : !in_c.z[hgcd_pkg::CW-1];
    if (pos) begin
      c_nxt.x = in_c.x - sy;
      c_nxt.y = in_c.y + sx;
      c_nxt.z = in_c.z - at;
    end else begin
      c_nxt.x = in_c.x + sy;
      c_nxt.y = in_c.y - sx;
      c_nxt.z = in_c.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign out_c = c_r;

endmodule

/* src/hgcd_sqrt_cell.sv */
// One digit step of a restoring integer square root, with its output register.
// Depends on hgcd_pkg.
`timescale 1ns / 1ps

module hgcd_sqrt_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hgcd_pkg::SQ_IDX_W-1:0] step,
  input  hgcd_pkg::sqrt_t               in_s,
  output hgcd_pkg::sqrt_t               out_s
);

  logic [hgcd_pkg::SW-1:0] bitv;
  logic [hgcd_pkg::SW-1:0] trial;
  hgcd_pkg::sqrt_t         s_nxt;
  hgcd_pkg::sqrt_t         s_r;

  // Digit weight is 4^(30 - step)
  always_comb begin
    bitv  = hgcd_pkg::SW'(1) << (hgcd_pkg::SW - 1 - 2 * int'(step));
    trial = in_s.root + bitv;
    if (in_s.rem >= trial) begin
      s_nxt.rem  = in_s.rem - trial;
      s_nxt.root = (in_s.root >> 1) + bitv;
    end else begin
      s_nxt.rem  = in_s.rem;
      s_nxt.root = in_s.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end

  assign out_s = s_r;

endmodule

/* src/haversine_great_circle_distance.sv */
// Top level of the haversine distance pipeline: angle front ends, CORDIC and square
// root cell chains, products and scaling. Depends on hgcd_pkg and all hgcd_ cells.
`timescale 1ns / 1ps

// Fully pipelined: one coordinate pair is accepted every cycle while out_tready is high,
// and its distance passes through 1 input stage, 3 angle scaling stages,
// 32 sine/cosine CORDIC cells, 3 product stages, 31 square root digit cells,
// 32 vectoring CORDIC cells and 2 output scaling stages. The whole chain advances
// together; while a result waits on out_tready the pipeline holds and in_tready is low.
module haversine_great_circle_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [30:0] first_latitude, [62:31] first_longitude, [93:63] second_latitude,
  // [125:94] second_longitude, [127:126] zero
  input  logic [hgcd_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [30:0] distance_cm, [31] zero
  output logic [hgcd_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int N  = hgcd_pkg::CORDIC_STAGES;
  localparam int NQ = hgcd_pkg::SQRT_STEPS;

  logic                            adv;
  logic [hgcd_pkg::PIPE_LAT-1:0]   vld_r;
  logic signed [hgcd_pkg::LAT_W-1:0] lat1;
  logic signed [hgcd_pkg::LON_W-1:0] lon1;
  logic signed [hgcd_pkg::LAT_W-1:0] lat2;
  logic signed [hgcd_pkg::LON_W-1:0] lon2;
  logic signed [hgcd_pkg::HW-1:0]  h_r [4];
  logic signed [hgcd_pkg::CW-1:0]  prep_z [4];
  logic                            prep_ncos [4];
  hgcd_pkg::cordic_t               rot_c [4][N+1];
  logic                            ncos_r [N][2];
  logic signed [hgcd_pkg::CW-1:0]  c1;
  logic signed [hgcd_pkg::CW-1:0]  c2;
  logic signed [hgcd_pkg::CW-1:0]  m1_sqlat_r;
  logic signed [hgcd_pkg::CW-1:0]  m1_c12_r;
  logic signed [hgcd_pkg::CW-1:0]  m1_sqlon_r;
  logic signed [hgcd_pkg::CW-1:0]  m2_sqlat_r;
  logic signed [hgcd_pkg::CW-1:0]  m2_t_r;
  logic signed [hgcd_pkg::CW-1:0]  a_sum;
  logic [30:0]                     a_nxt;
  logic [30:0]                     a_r;
  hgcd_pkg::sqrt_t                 sq_a [NQ+1];
  hgcd_pkg::sqrt_t                 sq_b [NQ+1];
  hgcd_pkg::cordic_t               vc [N+1];
  logic signed [hgcd_pkg::CW-1:0]  zf;
  logic [32:0]                     zc;
  logic [64:0]                     prod_f_r;
  logic [64:0]                     dsum;
  logic [34:0]                     dq;
  logic [hgcd_pkg::DIST_W-1:0]     d_nxt;
  logic [hgcd_pkg::DIST_W-1:0]     dist_r;

  // Whole chain moves when the output register is free or being drained
  assign adv       = !vld_r[hgcd_pkg::PIPE_LAT-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[hgcd_pkg::PIPE_LAT-2:0], in_tvalid};
    end
  end

  // Input unpack and half-unit angles
  assign lat1 = in_tdata[30:0];
  assign lon1 = in_tdata[62:31];
  assign lat2 = in_tdata[93:63];
  assign lon2 = in_tdata[125:94];

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r[0] <= hgcd_pkg::HW'(lat2) - hgcd_pkg::HW'(lat1);
      h_r[1] <= hgcd_pkg::HW'(lon2) - hgcd_pkg::HW'(lon1);
      h_r[2] <= hgcd_pkg::HW'(lat1) <<< 1;
      h_r[3] <= hgcd_pkg::HW'(lat2) <<< 1;
    end
  end

  // Sine and cosine lanes: dlat, dlon, lat1, lat2
  for (genvar l = 0; l < 4; l++) begin : g_lane
    hgcd_angle_prep u_prep (
      .clk     (clk),
      .en      (adv),
      .h       (h_r[l]),
      .z       (prep_z[l]),
      .neg_cos (prep_ncos[l])
    );

    assign rot_c[l][0] = '{x: hgcd_pkg::CORDIC_GAIN, y: '0, z: prep_z[l]};

    for (genvar k = 0; k < N; k++) begin : g_rot
      hgcd_cordic_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .vec   (1'b0),
        .stage (hgcd_pkg::IDX_W'(k)),
        .in_c  (rot_c[l][k]),
        .out_c (rot_c[l][k+1])
      );
    end
  end

  // Cosine sign flags ride alongside the latitude lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      ncos_r[0][0] <= prep_ncos[2];
      ncos_r[0][1] <= prep_ncos[3];
      for (int k = 1; k < N; k++) begin
        ncos_r[k] <= ncos_r[k-1];
      end
    end
  end

  assign c1 = ncos_r[N-1][0] ? -rot_c[2][N].x : rot_c[2][N].x;
  assign c2 = ncos_r[N-1][1] ? -rot_c[3][N].x : rot_c[3][N].x;

  // Haversine term, clamped to [0, 1]
  always_comb begin
    a_sum = m2_sqlat_r + m2_t_r;
    if (a_sum < 0) begin
      a_nxt = '0;
    end else if (a_sum > hgcd_pkg::CW'(hgcd_pkg::Q30_ONE)) begin
      a_nxt = hgcd_pkg::Q30_ONE;
    end else begin
      a_nxt = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sqlat_r <= hgcd_pkg::mul_q30(rot_c[0][N].y, rot_c[0][N].y);
      m1_sqlon_r <= hgcd_pkg::mul_q30(rot_c[1][N].y, rot_c[1][N].y);
      m1_c12_r   <= hgcd_pkg::mul_q30(c1, c2);
      m2_sqlat_r <= m1_sqlat_r;
      m2_t_r     <= hgcd_pkg::mul_q30(m1_c12_r, m1_sqlon_r);
      a_r        <= a_nxt;
    end
  end

  // Square roots of a and 1 - a
  assign sq_a[0] = '{rem: hgcd_pkg::SW'(a_r) << 30, root: '0};
  assign sq_b[0] = '{rem: hgcd_pkg::SW'(hgcd_pkg::Q30_ONE - a_r) << 30, root: '0};

  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    hgcd_sqrt_cell u_sqa (
      .clk   (clk),
      .en    (adv),
      .step  (hgcd_pkg::SQ_IDX_W'(k)),
      .in_s  (sq_a[k]),
      .out_s (sq_a[k+1])
    );
    hgcd_sqrt_cell u_sqb (
      .clk   (clk),
      .en    (adv),
      .step  (hgcd_pkg::SQ_IDX_W'(k)),
      .in_s  (sq_b[k]),
      .out_s (sq_b[k+1])
    );
  end

  // Central angle by vectoring
  assign vc[0] = '{x: hgcd_pkg::CW'($signed({1'b0, sq_b[NQ].root[30:0]})),
                   y: hgcd_pkg::CW'($signed({1'b0, sq_a[NQ].root[30:0]})),
                   z: '0};

  for (genvar k = 0; k < N; k++) begin : g_vec
    hgcd_cordic_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .vec   (1'b1),
      .stage (hgcd_pkg::IDX_W'(k)),
      .in_c  (vc[k]),
      .out_c (vc[k+1])
    );
  end

  // Scale to centimeters, round and saturate
  assign zf = vc[N].z;
  assign zc = zf[hgcd_pkg::CW-1] ? '0 : zf[32:0];

  always_comb begin
    dsum = prod_f_r + 65'h2000_0000;
    dq   = dsum[64:30];
    if (dq > 35'(hgcd_pkg::DIST_MAX)) begin
      d_nxt = hgcd_pkg::DIST_MAX;
    end else begin
      d_nxt = dq[hgcd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_f_r <= 65'(zc) * 65'(hgcd_pkg::RADIUS2_CM);
      dist_r   <= d_nxt;
    end
  end

  assign out_tvalid = vld_r[hgcd_pkg::PIPE_LAT-1];
  assign out_tdata  = {1'b0, dist_r};

endmodule

/* src/hgcd_checker.sv */
// Port-level checks for the haversine distance block, bound to the top level.
// Depends on hgcd_pkg.
`timescale 1ns / 1ps

module hgcd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hgcd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Distance never exceeds the half circumference
  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[hgcd_pkg::DIST_W-1:0] <= hgcd_pkg::DIST_MAX)
    else $error("distance above half circumference");

  // Padding bit stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[hgcd_pkg::OUT_DATA_W-1] == 1'b0)
    else $error("output padding bit set");

  // With no result pending the pipeline always takes input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind haversine_great_circle_distance hgcd_checker u_hgcd_checker (.*);
